/* sv/dvcl_pkg.sv */
// package with the shared payload type and constants of the voltage circle limiter
`timescale 1ns / 1ps
package dvcl_pkg;

  // number of result bits produced by the square root and divider rows
  localparam int unsigned ROOT_BITS = 16;
  localparam int unsigned STEP_W    = 4;

  // reset value of the magnitude limit, 24.0 V in Q8.8
  localparam logic [15:0] LIMIT_RESET = 16'd6144;

  // floor(x / 3) for 17-bit x as (x * ceil(2^18 / 3)) >> 18
  localparam logic [17:0] DIV3_RECIP = 18'd87382;
  localparam int unsigned DIV3_SHIFT = 18;

  // payload that travels down the chain
  typedef struct packed {
    logic signed [15:0] vd;
    logic signed [15:0] vq;
    logic signed [15:0] vz;
    logic               lim;
    logic [15:0]        allowed;
    logic [15:0]        ad;
    logic [15:0]        aq;
    logic [31:0]        asq;
    logic [31:0]        sqd;
    logic [31:0]        sqq;
    logic [31:0]        x;
    logic [31:0]        res;
    logic [31:0]        rd;
    logic [31:0]        rq;
    logic [15:0]        qd;
    logic [15:0]        qq;
  } pkt_t;

endpackage

/* sv/dvcl_if.sv */
// channel interfaces for the input vector and the limited result
`timescale 1ns / 1ps
interface dvcl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vd;
  logic signed [15:0] vq;
  logic signed [15:0] v_zero;
  logic [15:0]        bus_voltage;
  modport source (output valid, vd, vq, v_zero, bus_voltage, input ready);
  modport sink   (input valid, vd, vq, v_zero, bus_voltage, output ready);
endinterface

interface dvcl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vd_out;
  logic signed [15:0] vq_out;
  logic signed [15:0] v_zero_out;
  logic               was_limited;
  modport source (output valid, vd_out, vq_out, v_zero_out, was_limited, input ready);
  modport sink   (input valid, vd_out, vq_out, v_zero_out, was_limited, output ready);
endinterface

/* sv/dvcl_prep.sv */
// front stages: allowed magnitude, squares, limit decision and scaled numerators
`timescale 1ns / 1ps
module dvcl_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  logic signed [15:0] vd,
  input  logic signed [15:0] vq,
  input  logic signed [15:0] vz,
  input  logic [15:0]        bus_voltage,
  input  logic [15:0]        mag_limit,
  output logic               vld_out,
  output dvcl_pkg::pkt_t     pkt_out
);
  import dvcl_pkg::*;

  logic [2:0]  vld_r;
  pkt_t        s0_r, s1_r, s2_r;
  pkt_t        s0_nxt, s1_nxt, s2_nxt;
  logic [34:0] third_prod;
  logic [16:0] third;
  logic [31:0] sum;

  // stage 0: two thirds of bus voltage, clamp to limit, magnitudes
  always_comb begin
    s0_nxt     = '0;
    s0_nxt.vd  = vd;
    s0_nxt.vq  = vq;
    s0_nxt.vz  = vz;
    third_prod = 35'({bus_voltage, 1'b0}) * 35'(DIV3_RECIP);
    third      = third_prod[DIV3_SHIFT +: 17];
    s0_nxt.allowed = (third > 17'(mag_limit)) ? mag_limit : third[15:0];
    s0_nxt.ad  = vd[15] ? 16'(-17'(vd)) : 16'(vd);
    s0_nxt.aq  = vq[15] ? 16'(-17'(vq)) : 16'(vq);
  end

  // stage 1: squares
  always_comb begin
    s1_nxt     = s0_r;
    s1_nxt.sqd = 32'(s0_r.ad) * 32'(s0_r.ad);
    s1_nxt.sqq = 32'(s0_r.aq) * 32'(s0_r.aq);
    s1_nxt.asq = 32'(s0_r.allowed) * 32'(s0_r.allowed);
  end

  // stage 2: sum of squares, strict compare, numerators for the divider
  always_comb begin
    sum        = s1_r.sqd + s1_r.sqq;
    s2_nxt     = s1_r;
    s2_nxt.lim = s1_r.asq < sum;
    s2_nxt.x   = sum;
    s2_nxt.res = '0;
    s2_nxt.rd  = 32'(s1_r.ad) * 32'(s1_r.allowed);
    s2_nxt.rq  = 32'(s1_r.aq) * 32'(s1_r.allowed);
    s2_nxt.qd  = '0;
    s2_nxt.qq  = '0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_in};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign vld_out = vld_r[2];
  assign pkt_out = s2_r;
endmodule

/* sv/dvcl_sqrt_cell.sv */
// one bit of the digit-by-digit integer square root
`timescale 1ns / 1ps
module dvcl_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [dvcl_pkg::STEP_W-1:0] step,
  input  logic                        vld_in,
  input  dvcl_pkg::pkt_t              pkt_in,
  output logic                        vld_out,
  output dvcl_pkg::pkt_t              pkt_out
);
  import dvcl_pkg::*;

  logic        vld_r;
  pkt_t        pkt_r, pkt_nxt;
  logic [31:0] bit_val;
  logic [31:0] trial;

  // try the next root bit against the remainder
  always_comb begin
    bit_val = 32'd1 << {step, 1'b0};
    trial   = pkt_in.res + bit_val;
    pkt_nxt = pkt_in;
    if (pkt_in.x >= trial) begin
      pkt_nxt.x   = pkt_in.x - trial;
      pkt_nxt.res = (pkt_in.res >> 1) + bit_val;
    end else begin
      pkt_nxt.res = pkt_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign vld_out = vld_r;
  assign pkt_out = pkt_r;
endmodule

/* sv/dvcl_div_cell.sv */
// one quotient bit of the restoring divider for both axes
`timescale 1ns / 1ps
module dvcl_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [dvcl_pkg::STEP_W-1:0] step,
  input  logic                        vld_in,
  input  dvcl_pkg::pkt_t              pkt_in,
  output logic                        vld_out,
  output dvcl_pkg::pkt_t              pkt_out
);
  import dvcl_pkg::*;

  logic        vld_r;
  pkt_t        pkt_r, pkt_nxt;
  logic [31:0] dvs;

  // divisor is the root, shifted to this quotient bit
  always_comb begin
    dvs     = {16'd0, pkt_in.res[15:0]} << step;
    pkt_nxt = pkt_in;
    if (pkt_in.rd >= dvs) begin
      pkt_nxt.rd       = pkt_in.rd - dvs;
      pkt_nxt.qd[step] = 1'b1;
    end
    if (pkt_in.rq >= dvs) begin
      pkt_nxt.rq       = pkt_in.rq - dvs;
      pkt_nxt.qq[step] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign vld_out = vld_r;
  assign pkt_out = pkt_r;
endmodule

/* sv/dq_voltage_circle_limit_top.sv */
// top level of the dq voltage circle limiter
`timescale 1ns / 1ps
// Limits the (vd, vq) vector to min(2/3 bus voltage, configured limit), all Q8.8.
// A new vector is taken every clock while no result waits untaken; from input
// transfer to the result being offered it passes three front stages (allowed
// magnitude, squares, compare), a row of 16 square root cells, a row of 16
// divider cells and the output register, one cell per root or quotient bit.
// The whole row advances together and holds while a result waits untaken.
module dq_voltage_circle_limit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  dvcl_in_if.sink     in_if,
  dvcl_out_if.source  out_if
);
  import dvcl_pkg::*;

  logic        adv;
  logic [15:0] limit_r;
  logic        pre_vld;
  pkt_t        pre_pkt;
  logic [ROOT_BITS:0] sq_vld;
  pkt_t               sq_pkt [ROOT_BITS+1];
  logic [ROOT_BITS:0] dv_vld;
  pkt_t               dv_pkt [ROOT_BITS+1];
  logic               out_vld_r;
  logic signed [15:0] vd_out_r, vq_out_r, vz_out_r;
  logic               lim_r;
  logic signed [15:0] vd_nxt, vq_nxt;
  pkt_t               fin;

  // whole pipeline moves unless a result is stuck at the output
  assign adv         = !out_vld_r || out_if.ready;
  assign in_if.ready = adv;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  dvcl_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .vld_in       (in_if.valid),
    .vd           (in_if.vd),
    .vq           (in_if.vq),
    .vz           (in_if.v_zero),
    .bus_voltage  (in_if.bus_voltage),
    .mag_limit    (limit_r),
    .vld_out      (pre_vld),
    .pkt_out      (pre_pkt)
  );

  assign sq_vld[0] = pre_vld;
  assign sq_pkt[0] = pre_pkt;

  // square root row, most significant bit first
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
    dvcl_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .step   (STEP_W'(ROOT_BITS - 1 - i)),
      .vld_in (sq_vld[i]),
      .pkt_in (sq_pkt[i]),
      .vld_out(sq_vld[i+1]),
      .pkt_out(sq_pkt[i+1])
    );
  end

  assign dv_vld[0] = sq_vld[ROOT_BITS];
  assign dv_pkt[0] = sq_pkt[ROOT_BITS];

  // divider row, most significant quotient bit first
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_div
    dvcl_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .step   (STEP_W'(ROOT_BITS - 1 - i)),
      .vld_in (dv_vld[i]),
      .pkt_in (dv_pkt[i]),
      .vld_out(dv_vld[i+1]),
      .pkt_out(dv_pkt[i+1])
    );
  end

  assign fin = dv_pkt[ROOT_BITS];

  // apply sign and saturate, or pass the vector unchanged
  always_comb begin
    vd_nxt = fin.vd;
    vq_nxt = fin.vq;
    if (fin.lim) begin
      if (fin.vd[15]) begin
        vd_nxt = (fin.qd > 16'd32768) ? -16'sd32768 : 16'(-17'(fin.qd));
      end else begin
        vd_nxt = (fin.qd > 16'd32767) ? 16'sd32767 : fin.qd;
      end
      if (fin.vq[15]) begin
        vq_nxt = (fin.qq > 16'd32768) ? -16'sd32768 : 16'(-17'(fin.qq));
      end else begin
        vq_nxt = (fin.qq > 16'd32767) ? 16'sd32767 : fin.qq;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vd_out_r <= vd_nxt;
      vq_out_r <= vq_nxt;
      vz_out_r <= fin.vz;
      lim_r    <= fin.lim;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.vd_out      = vd_out_r;
  assign out_if.vq_out      = vq_out_r;
  assign out_if.v_zero_out  = vz_out_r;
  assign out_if.was_limited = lim_r;

  // no result offered right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_vld_r)
    else $error("result valid after reset");

  // a stalled row keeps the valid bits of the root and divider rows
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sq_vld) && $stable(dv_vld))
    else $error("pipeline moved while stalled");

  // an input transfer reaches the front of the root row through the three front stages when unstalled
  a_front_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && adv ##1 adv ##1 adv |=> sq_vld[0])
    else $error("input transfer lost in front stages");
endmodule
